/* design/plo_pkg.sv */
// Package for the positional ordered list: sizes, request and status codes,
// and the per-cell operation code. No dependencies.
package plo_pkg;

    // Number of cells in the chain.
    localparam int CAPACITY = 16;

    // Width of the stored values.
    localparam int VAL_W = 32;

    // Widths of the narrow fields of a transaction.
    localparam int REQ_W = 2;
    localparam int POS_W = 5;
    localparam int IDX_OUT_W = 5;
    localparam int STAT_W = 2;

    // Counter width: it must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Common width for comparing positions against the count.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // A dump streams at most this many values.
    localparam int MAX_DUMP = 16;

    // Cells that a dump can reach, and the index width over them.
    localparam int DUMP_CELLS = (CAPACITY < MAX_DUMP) ? CAPACITY : MAX_DUMP;
    localparam int DUMP_IW = (DUMP_CELLS > 1) ? $clog2(DUMP_CELLS) : 1;

    // Request kinds.
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_DUMP   = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // What one cell does on a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } t_cell_op;

endpackage

/* design/plo_if.sv */
// Channel interfaces for the positional ordered list: request and response.
// Depends on plo_pkg for the field widths.
interface plo_in_if;
    logic                              valid;
    logic                              ready;
    logic [plo_pkg::REQ_W-1:0]         req_type;
    logic signed [plo_pkg::VAL_W-1:0]  item_value;
    logic [plo_pkg::POS_W-1:0]         position;

    modport source (output valid, req_type, item_value, position, input ready);
    modport sink   (input valid, req_type, item_value, position, output ready);
endinterface

interface plo_out_if;
    logic                              valid;
    logic                              ready;
    logic [plo_pkg::STAT_W-1:0]        status;
    logic signed [plo_pkg::VAL_W-1:0]  out_value;
    logic [plo_pkg::IDX_OUT_W-1:0]     out_index;
    logic [plo_pkg::IDX_OUT_W-1:0]     entry_count;
    logic                              last;

    modport source (output valid, status, out_value, out_index, entry_count, last,
                    input ready);
    modport sink   (input valid, status, out_value, out_index, entry_count, last,
                    output ready);
endinterface

/* design/plo_cell.sv */
// One storage cell of the list chain: holds one value and can take a new
// value or its left or right neighbor's value. Depends on plo_pkg.
module plo_cell (
    input  logic                              i_clk,
    input  plo_pkg::t_cell_op                 i_op,
    input  logic signed [plo_pkg::VAL_W-1:0]  i_new_value,
    input  logic signed [plo_pkg::VAL_W-1:0]  i_left_value,
    input  logic signed [plo_pkg::VAL_W-1:0]  i_right_value,
    output logic signed [plo_pkg::VAL_W-1:0]  o_value
);

    logic signed [plo_pkg::VAL_W-1:0] r_value;
    logic signed [plo_pkg::VAL_W-1:0] n_value;

    // Select the next stored value from the operation.
    always_comb begin
        case (i_op)
            plo_pkg::CELL_LOAD:       n_value = i_new_value;
            plo_pkg::CELL_FROM_LEFT:  n_value = i_left_value;
            plo_pkg::CELL_FROM_RIGHT: n_value = i_right_value;
            default:                  n_value = r_value;
        endcase
    end

    // The value is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* design/positional_ordered_list_top.sv */
// Top level of the positional ordered list: the chain of cells, the count,
// the request decode, the dump sequencer and the response register.
// Depends on plo_pkg, plo_if and plo_cell.

// Positional ordered list. Holds up to CAPACITY signed 32-bit values in a
// row of cells that shift toward each other, so append, insert and delete
// each take one transaction in and one response out. A dump of n stored
// values (at most 16) gives n responses, one per cycle while the response
// side takes them, read out of the first cells through one output register;
// while it runs, no request is accepted. A response waits in the output
// register while the next request is accepted as soon as that register is
// taken or empty. Bad positions, a full list and an empty list give a status
// code and leave the list as it was. The values of cells above the count
// never reach a response.
module positional_ordered_list_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plo_in_if.sink    i_req,
    plo_out_if.source o_rsp
);

    localparam int CAP = plo_pkg::CAPACITY;
    localparam int CW  = plo_pkg::CMP_W;

    // Control and response registers.
    logic [plo_pkg::CNT_W-1:0]        r_count, n_count;
    logic                             r_dumping, n_dumping;
    logic [plo_pkg::DUMP_IW-1:0]      r_dump_idx, n_dump_idx;
    logic                             r_out_valid, n_out_valid;
    plo_pkg::t_status                 r_status, n_status;
    logic signed [plo_pkg::VAL_W-1:0] r_value, n_value;
    logic [plo_pkg::IDX_OUT_W-1:0]    r_index, n_index;
    logic [plo_pkg::IDX_OUT_W-1:0]    r_entry, n_entry;
    logic                             r_last, n_last;

    // Chain wiring.
    plo_pkg::t_cell_op                w_ops   [CAP];
    logic signed [plo_pkg::VAL_W-1:0] w_cells [CAP];
    logic signed [plo_pkg::VAL_W-1:0] w_dump_cells [plo_pkg::DUMP_CELLS];

    logic          w_accept;
    logic          w_slot_free;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_pos_m1;
    logic [CW-1:0] w_cnt;
    logic [CW-1:0] w_dump_n;
    logic          w_full;
    logic          w_empty;
    logic          w_ins_bad;
    logic          w_del_bad;
    logic [CW-1:0] w_next_idx;

    // Handshake: the output register is free when empty or being taken.
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_dumping && w_slot_free;
    assign w_accept    = i_req.valid && i_req.ready;

    // Position checks in a common width.
    assign w_pos     = CW'(i_req.position);
    assign w_pos_m1  = w_pos - CW'(1);
    assign w_cnt     = CW'(r_count);
    assign w_full    = (w_cnt == CW'(CAP));
    assign w_empty   = (r_count == '0);
    assign w_ins_bad = (w_pos == '0) || (w_pos > w_cnt + CW'(1));
    assign w_del_bad = (w_pos == '0) || (w_pos > w_cnt);
    assign w_dump_n  = (w_cnt > CW'(plo_pkg::MAX_DUMP)) ? CW'(plo_pkg::MAX_DUMP) : w_cnt;
    assign w_next_idx = CW'(r_dump_idx) + CW'(1);

    // Per-cell operation, decided from each cell's own index.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            w_ops[i] = plo_pkg::CELL_HOLD;
            if (w_accept) begin
                case (plo_pkg::t_req'(i_req.req_type))
                    plo_pkg::REQ_APPEND: begin
                        if (!w_full && CW'(i) == w_cnt) begin
                            w_ops[i] = plo_pkg::CELL_LOAD;
                        end
                    end
                    plo_pkg::REQ_INSERT: begin
                        if (!w_ins_bad && !w_full) begin
                            if (CW'(i) == w_pos_m1) begin
                                w_ops[i] = plo_pkg::CELL_LOAD;
                            end else if (CW'(i) > w_pos_m1) begin
                                w_ops[i] = plo_pkg::CELL_FROM_LEFT;
                            end
                        end
                    end
                    plo_pkg::REQ_DELETE: begin
                        if (!w_empty && !w_del_bad && CW'(i) >= w_pos_m1) begin
                            w_ops[i] = plo_pkg::CELL_FROM_RIGHT;
                        end
                    end
                    default: begin
                        w_ops[i] = plo_pkg::CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // The chain of cells; the ends see the new value and their own value.
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        plo_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (w_ops[g]),
            .i_new_value   (i_req.item_value),
            .i_left_value  ((g == 0) ? i_req.item_value : w_cells[(g == 0) ? 0 : g - 1]),
            .i_right_value ((g == CAP - 1) ? w_cells[g] : w_cells[(g == CAP - 1) ? g : g + 1]),
            .o_value       (w_cells[g])
        );
    end

    // Only the first cells can be dumped.
    for (genvar d = 0; d < plo_pkg::DUMP_CELLS; d++) begin : g_dump
        assign w_dump_cells[d] = w_cells[d];
    end

    // Request decode, dump sequencing and response loading.
    always_comb begin
        n_count     = r_count;
        n_dumping   = r_dumping;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value     = r_value;
        n_index     = r_index;
        n_entry     = r_entry;
        n_last      = r_last;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = plo_pkg::ST_OK;
            n_value     = '0;
            n_index     = '0;
            n_last      = 1'b1;
            case (plo_pkg::t_req'(i_req.req_type))
                plo_pkg::REQ_APPEND: begin
                    if (w_full) begin
                        n_status = plo_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + plo_pkg::CNT_W'(1);
                    end
                end
                plo_pkg::REQ_INSERT: begin
                    if (w_ins_bad) begin
                        n_status = plo_pkg::ST_BAD_POS;
                    end else if (w_full) begin
                        n_status = plo_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + plo_pkg::CNT_W'(1);
                    end
                end
                plo_pkg::REQ_DELETE: begin
                    if (w_empty) begin
                        n_status = plo_pkg::ST_EMPTY;
                    end else if (w_del_bad) begin
                        n_status = plo_pkg::ST_BAD_POS;
                    end else begin
                        n_count = r_count - plo_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    // Dump: the first value goes out now, the rest follow.
                    if (w_empty) begin
                        n_status = plo_pkg::ST_EMPTY;
                    end else begin
                        n_value    = w_dump_cells[0];
                        n_index    = plo_pkg::IDX_OUT_W'(1);
                        n_last     = (w_dump_n == CW'(1));
                        n_dumping  = (w_dump_n != CW'(1));
                        n_dump_idx = plo_pkg::DUMP_IW'(1);
                    end
                end
            endcase
            n_entry = plo_pkg::IDX_OUT_W'(n_count);
        end else if (r_dumping && w_slot_free) begin
            // Stream the next dumped value.
            n_out_valid = 1'b1;
            n_status    = plo_pkg::ST_OK;
            n_value     = w_dump_cells[r_dump_idx];
            n_index     = plo_pkg::IDX_OUT_W'(w_next_idx);
            n_entry     = plo_pkg::IDX_OUT_W'(r_count);
            n_last      = (w_next_idx == w_dump_n);
            if (w_next_idx == w_dump_n) begin
                n_dumping = 1'b0;
            end else begin
                n_dump_idx = r_dump_idx + plo_pkg::DUMP_IW'(1);
            end
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state is reset; the response payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dumping   <= 1'b0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dumping   <= n_dumping;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_index  <= n_index;
        r_entry  <= n_entry;
        r_last   <= n_last;
    end

    // Response channel.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_value   = r_value;
    assign o_rsp.out_index   = r_index;
    assign o_rsp.entry_count = r_entry;
    assign o_rsp.last        = r_last;

endmodule

/* tb/tb_plo_checker.sv */
// Checker for the positional ordered list: watches the request and response
// channels, keeps a shadow copy of the list and compares every response.
// Depends on plo_pkg and the channel interfaces in plo_if.
`timescale 1ns / 1ps

module tb_plo_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    plo_in_if    i_req,
    plo_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_list_len
);
    import plo_pkg::*;

    // One response as the list should produce it.
    typedef struct {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [IDX_OUT_W-1:0]    index;
        logic [IDX_OUT_W-1:0]    count;
        logic                    last;
    } t_list_rsp;

    // Shadow of the stored values and their number.
    logic signed [VAL_W-1:0] shadow_vals [int];
    int                      shadow_len;

    // Responses owed by the block, oldest first.
    t_list_rsp               owed_rsps [$];

    // Queue one owed response; the count is taken after the edit.
    function automatic void owe_rsp(t_status st, logic signed [VAL_W-1:0] v, int idx,
                                    logic is_last);
        t_list_rsp r;
        r.status = st;
        r.value  = v;
        r.index  = idx[IDX_OUT_W-1:0];
        r.count  = shadow_len[IDX_OUT_W-1:0];
        r.last   = is_last;
        owed_rsps.push_back(r);
    endfunction

    // Apply one accepted request to the shadow list and queue its responses.
    function automatic void apply_list_request(t_req kind, logic signed [VAL_W-1:0] v,
                                               logic [POS_W-1:0] p);
        int      pos;
        int      n;
        t_status st;
        pos = int'(p);
        st  = ST_OK;
        case (kind)
            REQ_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    shadow_vals[shadow_len] = v;
                    shadow_len++;
                end
            end
            REQ_INSERT: begin
                // A bad position wins over a full list.
                if (pos == 0 || pos > shadow_len + 1) begin
                    st = ST_BAD_POS;
                end else if (shadow_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    for (int i = shadow_len; i >= pos; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[pos-1] = v;
                    shadow_len++;
                end
            end
            REQ_DELETE: begin
                // An empty list wins over a bad position.
                if (shadow_len == 0) begin
                    st = ST_EMPTY;
                end else if (pos == 0 || pos > shadow_len) begin
                    st = ST_BAD_POS;
                end else begin
                    for (int i = pos; i < shadow_len; i++)
                        shadow_vals[i-1] = shadow_vals[i];
                    shadow_len--;
                end
            end
            default: begin
                if (shadow_len == 0) begin
                    owe_rsp(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    n = (shadow_len > MAX_DUMP) ? MAX_DUMP : shadow_len;
                    for (int i = 0; i < n; i++)
                        owe_rsp(ST_OK, shadow_vals[i], i + 1, (i + 1 == n));
                end
            end
        endcase
        if (kind != REQ_DUMP)
            owe_rsp(st, '0, 0, 1'b1);
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(string msg);
        $display("%0t ns: list mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // Compare one accepted response with the oldest owed one.
    task automatic check_list_rsp();
        t_list_rsp e;
        if (owed_rsps.size() == 0) begin
            report_mismatch("response transaction with nothing owed");
            return;
        end
        e = owed_rsps.pop_front();
        if (i_rsp.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", i_rsp.status, e.status));
        if (i_rsp.out_value !== e.value)
            report_mismatch($sformatf("out_value %0d, expected %0d", i_rsp.out_value,
                                      e.value));
        if (i_rsp.out_index !== e.index)
            report_mismatch($sformatf("out_index %0d, expected %0d", i_rsp.out_index,
                                      e.index));
        if (i_rsp.entry_count !== e.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", i_rsp.entry_count,
                                      e.count));
        if (i_rsp.last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", i_rsp.last, e.last));
    endtask

    // Watch both channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            owed_rsps.delete();
        end else begin
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                apply_list_request(t_req'(i_req.req_type), i_req.item_value, i_req.position);
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1)
                check_list_rsp();
        end
        o_pending  = owed_rsps.size();
        o_list_len = shadow_len;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the positional ordered list: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on plo_pkg, plo_if, positional_ordered_list_top and tb_plo_checker.
`timescale 1ns / 1ps

module tb;
    import plo_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 113;
    localparam int CALM_ITEMS   = 30;
    localparam int PHASE_LEN    = 20;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   rsp_stall;
    int   cycle_cnt;
    int   fail_count;
    int   pending;
    int   list_len;

    plo_in_if  req_ch ();
    plo_out_if rsp_ch ();

    positional_ordered_list_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tb_plo_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    always #CLK_HALF clk = ~clk;

    // Response back-pressure: random stall bursts, none in the calm tail.
    always @(negedge clk) begin
        if (calm) begin
            rsp_ch.ready = 1'b1;
        end else if (rsp_stall > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_stall--;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            rsp_stall = $urandom_range(1, 12) - 1;
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    // Cycle counter that ends a hung run.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Drive one request transaction, with an optional gap before it, and
    // return at the falling edge after it has been accepted.
    task automatic issue_request(t_req kind, logic signed [VAL_W-1:0] v,
                                 logic [POS_W-1:0] p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.req_type   = kind;
        req_ch.item_value = v;
        req_ch.position   = p;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
    endtask

    // Values lean on the sign and magnitude extremes now and then.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // One random request. Growing phases favor appends and inserts,
    // shrinking phases favor deletes; most positions are in range.
    task automatic random_request(bit grow);
        int               roll;
        int               len;
        t_req             kind;
        logic [POS_W-1:0] pos;
        len  = list_len;
        roll = $urandom_range(0, 99);
        if (grow)
            kind = (roll < 35) ? REQ_APPEND : (roll < 70) ? REQ_INSERT :
                   (roll < 88) ? REQ_DELETE : REQ_DUMP;
        else
            kind = (roll < 15) ? REQ_APPEND : (roll < 35) ? REQ_INSERT :
                   (roll < 85) ? REQ_DELETE : REQ_DUMP;
        pos = POS_W'($urandom_range(0, 31));
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            if (kind == REQ_INSERT)
                pos = POS_W'($urandom_range(1, len + 1));
            else if (kind == REQ_DELETE && len > 0)
                pos = POS_W'($urandom_range(1, len));
        end else if (roll < 93) begin
            // Just past the end of the legal range.
            pos = (kind == REQ_INSERT) ? POS_W'(len + 2) : POS_W'(len + 1);
        end
        issue_request(kind, pick_value(), pos);
    endtask

    initial begin
        rst_n             = 1'b0;
        calm              = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_APPEND;
        req_ch.item_value = '0;
        req_ch.position   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list: dump, deletes and inserts at bad positions.
        issue_request(REQ_DUMP, '0, 5'd0);
        issue_request(REQ_DELETE, '0, 5'd3);
        issue_request(REQ_DELETE, '0, 5'd0);
        issue_request(REQ_INSERT, 32'sd7, 5'd0);
        issue_request(REQ_INSERT, 32'sd7, 5'd2);

        // Build a short list with extreme values at the front, end and middle.
        issue_request(REQ_INSERT, 32'sh8000_0000, 5'd1);
        issue_request(REQ_APPEND, 32'sh7fff_ffff, 5'd31);
        issue_request(REQ_APPEND, -32'sd1, 5'd0);
        issue_request(REQ_INSERT, '0, POS_W'(list_len + 1));
        issue_request(REQ_INSERT, 32'sh5555_5555, 5'd2);

        // Delete at bad positions, dump, then delete the first and last.
        issue_request(REQ_DELETE, '0, 5'd0);
        issue_request(REQ_DELETE, '0, POS_W'(list_len + 1));
        issue_request(REQ_DUMP, '0, 5'd0);
        issue_request(REQ_DELETE, '0, 5'd1);
        issue_request(REQ_DELETE, '0, POS_W'(list_len));

        // Fill the list, then hit it with every full-list case.
        while (list_len < CAPACITY)
            issue_request(REQ_APPEND, $urandom, 5'd0);
        issue_request(REQ_APPEND, 32'sd1, 5'd0);
        issue_request(REQ_INSERT, 32'sd1, 5'd5);
        issue_request(REQ_INSERT, 32'sd1, 5'd17);
        issue_request(REQ_INSERT, 32'sd1, 5'd18);
        issue_request(REQ_INSERT, 32'shaaaa_aaaa, 5'd31);
        issue_request(REQ_DUMP, '0, 5'd0);
        issue_request(REQ_DELETE, '0, 5'd17);
        issue_request(REQ_DELETE, '0, 5'd16);
        issue_request(REQ_DELETE, '0, 5'd31);

        // Random part in alternating grow and shrink phases; calm tail.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            random_request(((i / PHASE_LEN) % 2) == 0);
        end
        req_ch.valid = 1'b0;

        // Drain every owed response, then allow for stragglers.
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
